// ===== sv/assert_macros.svh =====
// assertion macros included by the search block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication, off while reset is low
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is low
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== sv/stersrch_pkg.sv =====
// shared types, constants and microcode rom of the equal-range search block
package stersrch_pkg;

    // fixed field widths
    localparam int IDX_W       = 11;
    localparam int ENTRY_IDX_W = 10;
    localparam int IN_KEY_W    = 32;

    // parameter defaults
    localparam int DEF_TABLE_DEPTH = 1024;
    localparam int DEF_KEY_WIDTH   = 32;

    // opcodes
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    // sequencer steps
    typedef enum logic [2:0] {
        S_IDLE      = 3'd0,
        S_LB_ISSUE  = 3'd1,
        S_LB_CMP    = 3'd2,
        S_CHK_ISSUE = 3'd3,
        S_CHK_CMP   = 3'd4,
        S_UB_ISSUE  = 3'd5,
        S_UB_CMP    = 3'd6,
        S_EMIT      = 3'd7
    } t_step;

    // branch conditions
    typedef enum logic [2:0] {
        C_ALWAYS   = 3'd0,
        C_SEARCH   = 3'd1,
        C_LO_GE_HI = 3'd2,
        C_LO_GE_N  = 3'd3,
        C_KEY_NE   = 3'd4,
        C_OUT_FREE = 3'd5
    } t_cond;

    // one control word
    typedef struct packed {
        logic  take_in;
        logic  load_query;
        logic  rd_mid;
        logic  rd_lo;
        logic  lb_cmp;
        logic  ub_cmp;
        logic  check;
        logic  save_lower;
        logic  emit;
        t_cond cond;
        t_step jmp;
        t_step nxt;
    } t_uword;

    // microcode rom: jmp is taken when cond holds, else nxt
    function automatic t_uword uc_rom(input t_step step);
        t_uword w;
        w = '{take_in: 1'b0, load_query: 1'b0, rd_mid: 1'b0, rd_lo: 1'b0,
              lb_cmp: 1'b0, ub_cmp: 1'b0, check: 1'b0, save_lower: 1'b0,
              emit: 1'b0, cond: C_ALWAYS, jmp: S_IDLE, nxt: S_IDLE};
        case (step)
            S_IDLE: begin
                w.take_in    = 1'b1;
                w.load_query = 1'b1;
                w.cond       = C_SEARCH;
                w.jmp        = S_LB_ISSUE;
                w.nxt        = S_IDLE;
            end
            S_LB_ISSUE: begin
                w.rd_mid = 1'b1;
                w.cond   = C_LO_GE_HI;
                w.jmp    = S_CHK_ISSUE;
                w.nxt    = S_LB_CMP;
            end
            S_LB_CMP: begin
                w.lb_cmp = 1'b1;
                w.cond   = C_ALWAYS;
                w.jmp    = S_LB_ISSUE;
            end
            S_CHK_ISSUE: begin
                w.rd_lo      = 1'b1;
                w.save_lower = 1'b1;
                w.cond       = C_LO_GE_N;
                w.jmp        = S_EMIT;
                w.nxt        = S_CHK_CMP;
            end
            S_CHK_CMP: begin
                w.check = 1'b1;
                w.cond  = C_KEY_NE;
                w.jmp   = S_EMIT;
                w.nxt   = S_UB_ISSUE;
            end
            S_UB_ISSUE: begin
                w.rd_mid = 1'b1;
                w.cond   = C_LO_GE_HI;
                w.jmp    = S_EMIT;
                w.nxt    = S_UB_CMP;
            end
            S_UB_CMP: begin
                w.ub_cmp = 1'b1;
                w.cond   = C_ALWAYS;
                w.jmp    = S_UB_ISSUE;
            end
            S_EMIT: begin
                w.emit = 1'b1;
                w.cond = C_OUT_FREE;
                w.jmp  = S_IDLE;
                w.nxt  = S_EMIT;
            end
            default: begin
                w.cond = C_ALWAYS;
                w.jmp  = S_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

// ===== sv/sorted_table_equal_range_search_top.sv =====
// equal-range search over a sorted key table, run by a microcoded sequencer
//
//  channel  direction  handshake                  payload
//  in       to block   i_in_valid / o_in_stall    i_opcode i_entry_index i_entry_value i_search_key
//  out      from block o_out_valid / i_out_stall  o_found o_lower_index o_upper_index
//  cfg      to block   i_cfg_valid / o_cfg_ready  i_cfg_data (entry_count)
//
// a write item is taken in S_IDLE, which stays ready for the next item; a search runs a
// lower-bound binary search over the n entries in use, checks the key at that bound and,
// on a hit, an upper-bound search; a probe reads the key memory, then compares the read data.
// one item is worked on at a time; o_in_stall is high until the result is loaded.
// reset is synchronous, active low, and clears control state only; the key memory
// needs no clearing pass.
// a held result waits in the output register while i_out_stall is high.
`include "assert_macros.svh"

module sorted_table_equal_range_search_top
    import stersrch_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int KEY_WIDTH   = DEF_KEY_WIDTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // input item channel
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic                   i_opcode,
    input  logic [ENTRY_IDX_W-1:0] i_entry_index,
    input  logic [IN_KEY_W-1:0]    i_entry_value,
    input  logic [IN_KEY_W-1:0]    i_search_key,
    // result channel
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic                   o_found,
    output logic [IDX_W-1:0]       o_lower_index,
    output logic [IDX_W-1:0]       o_upper_index,
    // configuration channel
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [IDX_W-1:0]       i_cfg_data
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int MW = (AW > IDX_W) ? AW : IDX_W;
    localparam int XW = (KEY_WIDTH > IN_KEY_W) ? KEY_WIDTH : IN_KEY_W;
    localparam logic [16:0] DEPTH_V = 17'(TABLE_DEPTH);

    // control
    t_step  r_step, n_step;
    t_uword uw;
    logic   cond_hit;

    // datapath registers
    logic [IDX_W-1:0]     r_count;
    logic [IDX_W-1:0]     r_n;
    logic [IDX_W-1:0]     r_lo;
    logic [IDX_W-1:0]     r_hi;
    logic [IDX_W-1:0]     r_mid;
    logic [IDX_W-1:0]     r_lower;
    logic                 r_found;
    logic [KEY_WIDTH-1:0] r_key;
    logic [KEY_WIDTH-1:0] r_rdata;

    // result register
    logic                 r_out_valid;
    logic                 r_out_found;
    logic [IDX_W-1:0]     r_out_lower;
    logic [IDX_W-1:0]     r_out_upper;

    // key memory
    logic [KEY_WIDTH-1:0] mem [TABLE_DEPTH];

    logic                 in_xfer;
    logic                 wr_xfer;
    logic                 srch_xfer;
    logic                 out_free;
    logic [IDX_W-1:0]     mid;
    logic [IDX_W:0]       lo_hi_sum;
    logic [IDX_W-1:0]     count_sat;
    logic [IDX_W-1:0]     rd_sel;
    logic [MW-1:0]        rd_ext;
    logic [MW-1:0]        wr_ext;
    logic [AW-1:0]        rd_addr;
    logic [AW-1:0]        wr_addr;
    logic                 wr_in_range;
    logic [XW-1:0]        val_ext;
    logic [XW-1:0]        key_ext;
    logic                 rd_en;

    // handshakes
    assign uw         = uc_rom(r_step);
    assign o_in_stall = ~uw.take_in;
    assign in_xfer    = i_in_valid & uw.take_in;
    assign wr_xfer    = in_xfer & (i_opcode == OP_WRITE);
    assign srch_xfer  = in_xfer & (i_opcode == OP_SEARCH);
    assign out_free   = ~r_out_valid | ~i_out_stall;
    assign o_cfg_ready = 1'b1;

    // midpoint and saturated count
    assign lo_hi_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid       = lo_hi_sum[IDX_W:1];
    assign count_sat = (17'(r_count) > DEPTH_V) ? DEPTH_V[IDX_W-1:0] : r_count;

    // memory addressing and key sizing
    assign rd_sel      = uw.rd_lo ? r_lo : mid;
    assign rd_ext      = MW'(rd_sel);
    assign rd_addr     = rd_ext[AW-1:0];
    assign wr_ext      = MW'(i_entry_index);
    assign wr_addr     = wr_ext[AW-1:0];
    assign wr_in_range = 17'(i_entry_index) < DEPTH_V;
    assign val_ext     = XW'(i_entry_value);
    assign key_ext     = XW'(i_search_key);
    assign rd_en       = uw.rd_mid | uw.rd_lo;

    // branch condition select
    always_comb begin
        case (uw.cond)
            C_ALWAYS:   cond_hit = 1'b1;
            C_SEARCH:   cond_hit = srch_xfer;
            C_LO_GE_HI: cond_hit = r_lo >= r_hi;
            C_LO_GE_N:  cond_hit = r_lo >= r_n;
            C_KEY_NE:   cond_hit = r_rdata != r_key;
            C_OUT_FREE: cond_hit = out_free;
            default:    cond_hit = 1'b1;
        endcase
        n_step = cond_hit ? uw.jmp : uw.nxt;
    end

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= S_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    // entry count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_count <= i_cfg_data;
        end
    end

    // key memory, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (wr_xfer && wr_in_range) begin
            mem[wr_addr] <= val_ext[KEY_WIDTH-1:0];
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    // search datapath
    always_ff @(posedge i_clk) begin
        if (uw.load_query && srch_xfer) begin
            r_key   <= key_ext[KEY_WIDTH-1:0];
            r_n     <= count_sat;
            r_lo    <= '0;
            r_hi    <= count_sat;
            r_found <= 1'b0;
        end
        if (uw.rd_mid) begin
            r_mid <= mid;
        end
        if (uw.save_lower) begin
            r_lower <= r_lo;
        end
        if (uw.lb_cmp) begin
            if (r_rdata < r_key) begin
                r_lo <= r_mid + IDX_W'(1);
            end else begin
                r_hi <= r_mid;
            end
        end
        if (uw.ub_cmp) begin
            if (r_rdata <= r_key) begin
                r_lo <= r_mid + IDX_W'(1);
            end else begin
                r_hi <= r_mid;
            end
        end
        if (uw.check && (r_rdata == r_key)) begin
            r_found <= 1'b1;
            r_lo    <= r_lo + IDX_W'(1);
            r_hi    <= r_n;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (uw.emit && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (uw.emit && out_free) begin
            r_out_found <= r_found;
            r_out_lower <= r_lower;
            r_out_upper <= r_lo;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_found       = r_out_found;
    assign o_lower_index = r_out_lower;
    assign o_upper_index = r_out_upper;

    // checks
    `ASSERT_IMP(a_range_order, i_clk, i_rst_n, o_out_valid, o_lower_index <= o_upper_index, "lower index above upper index")
    `ASSERT_IMP(a_miss_empty, i_clk, i_rst_n, o_out_valid && !o_found, o_lower_index == o_upper_index, "miss with non-empty range")
    `ASSERT_IMP(a_probe_in_window, i_clk, i_rst_n, r_step == S_LB_CMP || r_step == S_UB_CMP, r_mid < r_hi, "probe outside search window")
    `ASSERT_NXT(a_emit_loads, i_clk, i_rst_n, r_step == S_EMIT && out_free, o_out_valid && r_step == S_IDLE, "result not loaded on emit")

endmodule

// ===== test/tb_sorted_table_equal_range_search_top.sv =====
// testbench for the equal-range search block: predicted ranges checked against every result

typedef struct packed {
    logic                           found;
    logic [stersrch_pkg::IDX_W-1:0] lower;
    logic [stersrch_pkg::IDX_W-1:0] upper;
} t_range_result;

// mirror of the key table and entry count, with the queue of ranges still due
class equal_range_board;
    localparam int DEPTH = stersrch_pkg::DEF_TABLE_DEPTH;

    bit [31:0]     keys [DEPTH];
    int unsigned   entry_cnt;
    t_range_result range_due_q [$];
    int            errors;
    int            n_writes;
    int            n_searches;
    int            n_results;

    function new();
        entry_cnt  = 0;
        errors     = 0;
        n_writes   = 0;
        n_searches = 0;
        n_results  = 0;
    endfunction

    // counts past the table depth saturate
    function void set_count(logic [stersrch_pkg::IDX_W-1:0] v);
        entry_cnt = (v > DEPTH) ? DEPTH : v;
    endfunction

    // first position in [lo, hi) whose key is not below k
    function int unsigned lower_bound_idx(bit [31:0] k, int unsigned lo, int unsigned hi);
        int unsigned mid;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (keys[mid] < k) lo = mid + 1;
            else hi = mid;
        end
        return lo;
    endfunction

    // first position in [lo, hi) whose key is above k
    function int unsigned upper_bound_idx(bit [31:0] k, int unsigned lo, int unsigned hi);
        int unsigned mid;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (keys[mid] <= k) lo = mid + 1;
            else hi = mid;
        end
        return lo;
    endfunction

    // accepted input transfer: update the table or queue the predicted range
    function void note_input(logic op, logic [9:0] idx, logic [31:0] val, logic [31:0] key);
        t_range_result r;
        int unsigned   lo;
        int unsigned   hi;
        if (op == stersrch_pkg::OP_WRITE) begin
            keys[idx] = val;
            n_writes++;
        end else begin
            lo = lower_bound_idx(key, 0, entry_cnt);
            hi = lo;
            r.found = 1'b0;
            if (lo < entry_cnt && keys[lo] == key) begin
                r.found = 1'b1;
                hi = upper_bound_idx(key, lo + 1, entry_cnt);
            end
            r.lower = lo[stersrch_pkg::IDX_W-1:0];
            r.upper = hi[stersrch_pkg::IDX_W-1:0];
            range_due_q.push_back(r);
            n_searches++;
        end
    endfunction

    // accepted result transfer: compare with the oldest predicted range
    function void check_result(logic found, logic [stersrch_pkg::IDX_W-1:0] lower,
                               logic [stersrch_pkg::IDX_W-1:0] upper);
        t_range_result e;
        n_results++;
        if (range_due_q.size() == 0) begin
            $display("%0t: unexpected result found=%b lower=%0d upper=%0d",
                     $time, found, lower, upper);
            errors++;
            return;
        end
        e = range_due_q.pop_front();
        if (found !== e.found) begin
            $display("%0t: found mismatch, expected %b actual %b", $time, e.found, found);
            errors++;
        end
        if (lower !== e.lower) begin
            $display("%0t: lower_index mismatch, expected %0d actual %0d",
                     $time, e.lower, lower);
            errors++;
        end
        if (upper !== e.upper) begin
            $display("%0t: upper_index mismatch, expected %0d actual %0d",
                     $time, e.upper, upper);
            errors++;
        end
    endfunction

    function int pending();
        return range_due_q.size();
    endfunction
endclass

module tb_sorted_table_equal_range_search_top;
    import stersrch_pkg::*;

    localparam int DEPTH        = DEF_TABLE_DEPTH;
    localparam int DRAIN_CYCLES = 60;
    localparam int HOLD_CYCLES  = 300;
    localparam logic [31:0] KEY_MAX = 32'hFFFF_FFFF;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_in_valid    = 1'b0;
    logic                   o_in_stall;
    logic                   i_opcode      = OP_WRITE;
    logic [ENTRY_IDX_W-1:0] i_entry_index = '0;
    logic [IN_KEY_W-1:0]    i_entry_value = '0;
    logic [IN_KEY_W-1:0]    i_search_key  = '0;
    logic                   o_out_valid;
    logic                   i_out_stall   = 1'b0;
    logic                   o_found;
    logic [IDX_W-1:0]       o_lower_index;
    logic [IDX_W-1:0]       o_upper_index;
    logic                   i_cfg_valid   = 1'b0;
    logic                   o_cfg_ready;
    logic [IDX_W-1:0]       i_cfg_data    = '0;

    equal_range_board sb = new();

    int send_idle_pct = 38;
    int recv_idle_pct = 70;
    int hold_trig     = 0;
    int hold_seen     = 0;
    int hold_left     = 0;
    int n_cfg         = 0;

    sorted_table_equal_range_search_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_opcode      (i_opcode),
        .i_entry_index (i_entry_index),
        .i_entry_value (i_entry_value),
        .i_search_key  (i_search_key),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_found       (o_found),
        .o_lower_index (o_lower_index),
        .o_upper_index (o_upper_index),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // receiver: random stall, or a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_trig != hold_seen) begin
            hold_seen = hold_trig;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall = 1'b1;
        end else begin
            i_out_stall = ($urandom_range(99) < recv_idle_pct);
        end
    end

    // result transfers
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(o_found, o_lower_index, o_upper_index);
    end

    // one input transfer; entered and left at a falling edge, valid stays high
    task automatic push_item(input logic op, input logic [9:0] idx,
                             input logic [31:0] val, input logic [31:0] key);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_opcode      = op;
        i_entry_index = idx;
        i_entry_value = val;
        i_search_key  = key;
        i_in_valid    = 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_input(op, idx, val, key);
        @(negedge i_clk);
    endtask

    // ignored fields carry random junk
    task automatic write_entry(input logic [9:0] idx, input logic [31:0] val);
        push_item(OP_WRITE, idx, val, $urandom);
    endtask

    task automatic search_key(input logic [31:0] key);
        push_item(OP_SEARCH, 10'($urandom), $urandom, key);
    endtask

    // drop valid, wait for all ranges and then for the block to go quiet
    task automatic settle();
        i_in_valid = 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_entry_count(input logic [IDX_W-1:0] v);
        i_cfg_data  = v;
        i_cfg_valid = 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.set_count(v);
        n_cfg++;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // fill entries 0..n-1 with non-decreasing keys, duplicates included
    task automatic fill_sorted(input int n, input logic [31:0] base);
        logic [32:0] nv;
        logic [31:0] v;
        int          r;
        v = base;
        for (int i = 0; i < n; i++) begin
            write_entry(i[9:0], v);
            r = $urandom_range(99);
            if (r < 30) nv = {1'b0, v};
            else if (r < 70) nv = {1'b0, v} + $urandom_range(3, 1);
            else nv = {1'b0, v} + ($urandom >> $urandom_range(31, 0));
            v = nv[32] ? KEY_MAX : nv[31:0];
        end
    endtask

    // mostly keys from the table or next to them, some edges and noise
    function automatic logic [31:0] pick_key(input int n);
        int r;
        int j;
        r = $urandom_range(99);
        if (n > 0) j = $urandom_range(n - 1, 0);
        if (r < 10) return 32'h0;
        if (r < 20) return KEY_MAX;
        if (r < 40 || n == 0) return $urandom;
        if (r < 80) return sb.keys[j];
        if (r < 90) return sb.keys[j] + 32'd1;
        return sb.keys[j] - 32'd1;
    endfunction

    // stimulus
    initial begin
        int          rand_items;
        int          phase;
        int          n;
        int          p;
        int          searches;
        logic [31:0] base;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // empty table straight out of reset
        search_key(32'h0);
        search_key(KEY_MAX);

        // small table with a run of duplicates and both key extremes
        write_entry(10'd0, 32'h0);
        write_entry(10'd1, 32'd5);
        write_entry(10'd2, 32'd5);
        write_entry(10'd3, 32'd5);
        write_entry(10'd4, KEY_MAX);
        write_entry(10'd1023, 32'h5A5A_5A5A);
        settle();
        set_entry_count(11'd5);
        search_key(32'h0);
        search_key(32'd5);
        search_key(32'd4);
        search_key(32'd6);
        search_key(KEY_MAX);
        search_key(32'd1);

        // keys beyond the last counted entry
        settle();
        set_entry_count(11'd3);
        search_key(32'd6);
        search_key(KEY_MAX);
        search_key(32'd5);

        // table made unsorted by an overwrite
        write_entry(10'd1, KEY_MAX);
        search_key(32'd5);
        search_key(KEY_MAX);
        search_key(32'h0);

        // random phases: new count, sorted fill, then searches with some writes mixed in
        rand_items = 0;
        phase      = 0;
        while (rand_items < 540) begin
            if (rand_items < 180) begin
                send_idle_pct = 38;
                recv_idle_pct = 70;
            end else if (rand_items < 360) begin
                send_idle_pct = 70;
                recv_idle_pct = 38;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case ($urandom_range(9))
                0:       n = 0;
                1, 2:    n = $urandom_range(100, 17);
                default: n = $urandom_range(16, 1);
            endcase
            settle();
            set_entry_count(n[IDX_W-1:0]);
            base = ($urandom_range(1)) ? 32'h0 : ($urandom >> $urandom_range(31, 0));
            fill_sorted(n, base);
            if (phase == 2) hold_trig++;
            searches = $urandom_range(25, 8);
            for (int s = 0; s < searches; s++) begin
                if ($urandom_range(99) < 15) write_entry(10'($urandom), $urandom);
                else search_key(pick_key(n));
            end
            rand_items += n + searches;
            phase++;
        end

        // counts at and beyond the depth; only the entries on the probe paths of
        // the lowest and highest key are written, each holding its own index
        settle();
        write_entry(10'd0, 32'h0);
        for (int b = 0; b < 10; b++) begin
            p = 1 << b;
            write_entry(p[9:0], 32'(p));
            p = DEPTH - p;
            write_entry(p[9:0], 32'(p));
        end
        settle();
        set_entry_count(11'd2047);
        search_key(32'h0);
        search_key(KEY_MAX);
        settle();
        set_entry_count(11'd1024);
        search_key(KEY_MAX);
        search_key(32'h0);
        settle();
        set_entry_count(11'd0);
        search_key(32'h0);
        search_key($urandom);

        settle();
        if (sb.pending() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, sb.pending());
            sb.errors++;
        end
        $display("covered %0d writes, %0d searches, %0d results, %0d entry count settings",
                 sb.n_writes, sb.n_searches, sb.n_results, n_cfg);
        $display("tables from empty to counts past the depth, with duplicates, misses and overwrites");
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // watchdog
    initial begin
        #4000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/stersrch_pkg.sv
sv/sorted_table_equal_range_search_top.sv
test/tb_sorted_table_equal_range_search_top.sv
